// File: sv/skt_pkg.sv
// Shared types and constants for the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

   localparam int KEY_W            = 64;
   localparam int POS_W            = 4;
   localparam int FOUND_W          = 4;
   localparam int TOTAL_W          = 5;
   localparam int CAPACITY_DEFAULT = 16;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [FOUND_W-1:0] found_index;
      logic [TOTAL_W-1:0] entry_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_SPARE = 4'b1000
   } state_type;

endpackage

// File: sv/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module skt_ram #(
   parameter int WIDTH = skt_pkg::KEY_W,
   parameter int DEPTH = skt_pkg::CAPACITY_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sorted_key_table.sv
// Sorted key table: ordered 64-bit key store with insert, delete and binary search.
`timescale 1ns / 1ps
//
// An item is taken at a rising edge with start high and busy low; unless it
// is answered at once, busy then stays high until the command is done. Each item
// gives one result, shown on rsp_item for a single cycle with rsp_strobe high;
// the receiver cannot stall it, and a new item may be started in that same cycle.
// All work goes through one RAM read port and 64-bit key compares, driven
// by a two-step sequencer: one state issues a read, the next compares and
// writes back. An insert shifts up each key greater than the new one, at most
// CAPACITY - 1 of them, and the new key lands in entry 0 when every key moves;
// a delete shifts down the keys above the position. A search ends on a hit,
// when the upper bound would drop below entry 0, or when the range runs out,
// after at most clog2(CAPACITY)+1 probes. A full table, bad position, empty
// search or unused command is answered without a sequencer step.
// The next item may start in the cycle of the strobe.
// Reset empties the table (count to zero); key storage is not cleared and
// is never used above the count. Unused command codes change nothing.
//
module sorted_key_table #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  skt_pkg::req_type req_item,
   output logic             rsp_strobe,
   output skt_pkg::rsp_type rsp_item
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = (CW > skt_pkg::POS_W) ? CW : skt_pkg::POS_W;

   skt_pkg::state_type state_ff, state_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [skt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            lo_ff, lo_in;
   logic [CW-1:0]            hi_ff, hi_in;
   skt_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   logic [skt_pkg::KEY_W-1:0] wr_data;
   logic [IW-1:0]             rd_addr;
   logic [skt_pkg::KEY_W-1:0] rd_data;
   logic [CW:0]               mid_sum;
   logic [CW-1:0]             mid;

   skt_ram #(
      .WIDTH(skt_pkg::KEY_W),
      .DEPTH(CAPACITY)
   ) u_keys (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = IW'(idx_ff);
      wr_data      = key_ff;
      rd_addr      = IW'(idx_ff);

      unique case (state_ff)
         skt_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in   = req_item.cmd;
               key_in   = req_item.key;
               lo_in    = '0;
               hi_in    = count_ff - CW'(1);
               idx_in   = count_ff;
               state_in = skt_pkg::ST_ISSUE;
               rsp_in.ok          = 1'b0;
               rsp_in.found_index = '0;
               rsp_in.entry_total = skt_pkg::TOTAL_W'(count_ff);
               priority if (req_item.cmd == skt_pkg::CMD_INSERT) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     state_in     = skt_pkg::ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               end else if (req_item.cmd == skt_pkg::CMD_DELETE) begin
                  if (WW'(req_item.position) >= WW'(count_ff)) begin
                     state_in     = skt_pkg::ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end else begin
                     idx_in = CW'(req_item.position) + CW'(1);
                  end
               end else if (req_item.cmd == skt_pkg::CMD_SEARCH) begin
                  if (count_ff == '0) begin
                     state_in     = skt_pkg::ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  state_in     = skt_pkg::ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end

         skt_pkg::ST_ISSUE: begin
            priority if (cmd_ff == skt_pkg::CMD_INSERT) begin
               if (idx_ff == '0) begin
                  wr_en              = 1'b1;
                  count_in           = count_ff + CW'(1);
                  rsp_in.ok          = 1'b1;
                  rsp_in.entry_total = skt_pkg::TOTAL_W'(count_in);
                  rsp_valid_in       = 1'b1;
                  state_in           = skt_pkg::ST_IDLE;
               end else begin
                  rd_addr  = IW'(idx_ff - CW'(1));
                  state_in = skt_pkg::ST_EVAL;
               end
            end else if (cmd_ff == skt_pkg::CMD_DELETE) begin
               if (idx_ff >= count_ff) begin
                  count_in           = count_ff - CW'(1);
                  rsp_in.ok          = 1'b1;
                  rsp_in.entry_total = skt_pkg::TOTAL_W'(count_in);
                  rsp_valid_in       = 1'b1;
                  state_in           = skt_pkg::ST_IDLE;
               end else begin
                  state_in = skt_pkg::ST_EVAL;
               end
            end else begin
               if (lo_ff > hi_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = skt_pkg::ST_IDLE;
               end else begin
                  idx_in   = mid;
                  rd_addr  = IW'(mid);
                  state_in = skt_pkg::ST_EVAL;
               end
            end
         end

         skt_pkg::ST_EVAL: begin
            state_in = skt_pkg::ST_ISSUE;
            priority if (cmd_ff == skt_pkg::CMD_INSERT) begin
               wr_en = 1'b1;
               if (rd_data > key_ff) begin
                  wr_data = rd_data;
                  idx_in  = idx_ff - CW'(1);
               end else begin
                  count_in           = count_ff + CW'(1);
                  rsp_in.ok          = 1'b1;
                  rsp_in.entry_total = skt_pkg::TOTAL_W'(count_in);
                  rsp_valid_in       = 1'b1;
                  state_in           = skt_pkg::ST_IDLE;
               end
            end else if (cmd_ff == skt_pkg::CMD_DELETE) begin
               wr_en   = 1'b1;
               wr_addr = IW'(idx_ff - CW'(1));
               wr_data = rd_data;
               idx_in  = idx_ff + CW'(1);
            end else begin
               priority if (rd_data == key_ff) begin
                  rsp_in.ok          = 1'b1;
                  rsp_in.found_index = skt_pkg::FOUND_W'(idx_ff);
                  rsp_valid_in       = 1'b1;
                  state_in           = skt_pkg::ST_IDLE;
               end else if (rd_data < key_ff) begin
                  lo_in = idx_ff + CW'(1);
               end else if (idx_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  state_in     = skt_pkg::ST_IDLE;
               end else begin
                  hi_in = idx_ff - CW'(1);
               end
            end
         end

         default: begin
            state_in = skt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != skt_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule
